FILE: hw/rtl/dbc_pkg.sv
// Shared types and constants of the digit blink controller.
// No dependencies. Used by the channel interfaces, dbc_step and digit_blink_controller.
package dbc_pkg;

	localparam int TIME_BITS   = 16;
	localparam int DIGIT_COUNT = 4;
	localparam int DIGIT_W     = 8;
	localparam int CFG_TIME_W  = 16;
	localparam int MASK_W      = 4;
	localparam int COUNT_W     = 8;
	localparam int OP_W        = 3;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;
	// Compare width wide enough for both the phase timer and a time register.
	localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

	localparam logic [CFG_TIME_W-1:0] OFF_TIME_RST    = CFG_TIME_W'(500);
	localparam logic [CFG_TIME_W-1:0] ON_TIME_RST     = CFG_TIME_W'(500);
	localparam logic [MASK_W-1:0]     BLINK_MASK_RST  = MASK_W'(15);
	localparam logic [COUNT_W-1:0]    BLINK_COUNT_RST = COUNT_W'(0);

	typedef enum logic [OP_W-1:0] {
		OP_TICK        = 3'd0,
		OP_START_CONT  = 3'd1,
		OP_START_COUNT = 3'd2,
		OP_STOP        = 3'd3,
		OP_LOAD        = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFF_TIME    = 8'd0,
		REG_ON_TIME     = 8'd1,
		REG_BLINK_MASK  = 8'd2,
		REG_BLINK_COUNT = 8'd3
	} reg_idx_t;

	typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digits_t;

	typedef struct packed {
		logic [CFG_TIME_W-1:0] off_time;
		logic [CFG_TIME_W-1:0] on_time;
		logic [MASK_W-1:0]     blink_mask;
		logic [COUNT_W-1:0]    blink_count;
	} cfg_t;

	typedef struct packed {
		digits_t              kept;
		digits_t              shown;
		logic [TIME_BITS-1:0] phase_timer;
		logic                 off_phase;
		logic                 repeating;
		logic                 count_armed;
		logic [COUNT_W-1:0]   blinks_done;
	} state_t;

endpackage

FILE: hw/rtl/dbc_if.sv
// Valid/ready channel interfaces of the digit blink controller.
// Depends on dbc_pkg for field widths.
interface dbc_item_if;
	logic                            valid;
	logic                            ready;
	logic [dbc_pkg::OP_W-1:0]        op;
	logic [dbc_pkg::DIGIT_W-1:0]     load_digit0;
	logic [dbc_pkg::DIGIT_W-1:0]     load_digit1;
	logic [dbc_pkg::DIGIT_W-1:0]     load_digit2;
	logic [dbc_pkg::DIGIT_W-1:0]     load_digit3;

	modport source (output valid, op, load_digit0, load_digit1, load_digit2, load_digit3,
		input ready);
	modport sink (input valid, op, load_digit0, load_digit1, load_digit2, load_digit3,
		output ready);
endinterface

interface dbc_result_if;
	logic                            valid;
	logic                            ready;
	logic [dbc_pkg::DIGIT_W-1:0]     show_digit0;
	logic [dbc_pkg::DIGIT_W-1:0]     show_digit1;
	logic [dbc_pkg::DIGIT_W-1:0]     show_digit2;
	logic [dbc_pkg::DIGIT_W-1:0]     show_digit3;
	logic                            in_off_phase;
	logic                            run_done;

	modport source (output valid, show_digit0, show_digit1, show_digit2, show_digit3,
		in_off_phase, run_done, input ready);
	modport sink (input valid, show_digit0, show_digit1, show_digit2, show_digit3,
		in_off_phase, run_done, output ready);
endinterface

interface dbc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dbc_pkg::CFG_IDX_W-1:0]   index;
	logic [dbc_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dbc_step.sv
// Next-state and result logic for one item of the digit blink controller.
// Depends on dbc_pkg.
module dbc_step (
	input  dbc_pkg::state_t                   cur,
	input  dbc_pkg::cfg_t                     cfg,
	input  logic [dbc_pkg::OP_W-1:0]          op,
	input  dbc_pkg::digits_t                  load_digits,
	output dbc_pkg::state_t                   nxt,
	output logic                              done
);

	function automatic dbc_pkg::digits_t masked(input dbc_pkg::digits_t kept,
		input logic [dbc_pkg::MASK_W-1:0] mask);
		dbc_pkg::digits_t r;
		for (int i = 0; i < dbc_pkg::DIGIT_COUNT; i++) begin
			// Mask bit 3 belongs to digit 0.
			r[i] = mask[dbc_pkg::DIGIT_COUNT-1-i] ? '0 : kept[i];
		end
		return r;
	endfunction

	logic [dbc_pkg::TIME_BITS-1:0] timer_inc;
	logic                          off_done;
	logic                          on_done;
	logic                          after_off;
	logic [dbc_pkg::TIME_BITS-1:0] timer_a;
	logic [dbc_pkg::COUNT_W-1:0]   blinks_a;

	always_comb begin
		timer_inc = (cur.phase_timer != '1) ? cur.phase_timer + 1'b1 : cur.phase_timer;
		off_done  = cur.off_phase &&
			(dbc_pkg::CMP_W'(timer_inc) >= dbc_pkg::CMP_W'(cfg.off_time));
		after_off = cur.off_phase && !off_done;
		timer_a   = off_done ? '0 : timer_inc;
		blinks_a  = (off_done && cur.blinks_done != '1) ? cur.blinks_done + 1'b1
			: cur.blinks_done;
		on_done   = cur.repeating && !after_off &&
			(dbc_pkg::CMP_W'(timer_a) >= dbc_pkg::CMP_W'(cfg.on_time));
	end

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		case (op)
			dbc_pkg::OP_TICK: begin
				nxt.phase_timer = timer_a;
				nxt.blinks_done = blinks_a;
				nxt.off_phase   = after_off;
				if (off_done) begin
					nxt.shown = cur.kept;
				end
				if (on_done) begin
					nxt.off_phase   = 1'b1;
					nxt.phase_timer = '0;
					nxt.shown       = masked(cur.kept, cfg.blink_mask);
				end
				if (cur.count_armed && cfg.blink_count != '0 &&
					blinks_a == cfg.blink_count) begin
					nxt.repeating   = 1'b0;
					nxt.count_armed = 1'b0;
					done            = 1'b1;
				end
			end
			dbc_pkg::OP_START_CONT, dbc_pkg::OP_START_COUNT: begin
				if (op == dbc_pkg::OP_START_COUNT) begin
					nxt.blinks_done = '0;
					nxt.count_armed = 1'b1;
				end
				nxt.repeating = 1'b1;
				if (!cur.off_phase) begin
					nxt.off_phase   = 1'b1;
					nxt.phase_timer = '0;
					nxt.shown       = masked(cur.kept, cfg.blink_mask);
				end
			end
			dbc_pkg::OP_STOP: begin
				nxt.repeating = 1'b0;
			end
			dbc_pkg::OP_LOAD: begin
				nxt.kept  = load_digits;
				nxt.shown = load_digits;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/digit_blink_controller.sv
// Top level of the digit blink controller: channel handshakes, state and result registers.
// Depends on dbc_pkg, the channel interfaces in dbc_if.sv and dbc_step.
//
// The controller holds four segment patterns and drives them to a four-digit
// display, blanking the digits chosen by blink_mask during each off phase.
// Time moves only on tick items, one per millisecond; every item, tick or
// command, returns exactly one result with the patterns now shown, the off
// phase flag and a run_done pulse on the tick that completes a counted run.
// An item passes from transfer into the input register and then through the
// step logic into the result register. A new item can be transferred every
// cycle, because the step logic is a single short pass of increments and
// compares that updates the state registers in the same cycle that the result
// is written; the item port stalls only while the result register is full
// and its sink is not taking it. Configuration writes (index 0 off_time,
// 1 on_time, 2 blink_mask, 3 blink_count; other indexes are ignored) are
// always taken and act at the next compare or blink start, and are meant to
// be written only while no item is in flight.
module digit_blink_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	dbc_item_if.sink             item,
	dbc_result_if.source         result,
	dbc_cfg_if.sink              cfg
);

	// Input register.
	logic                            valid_s1;
	logic [dbc_pkg::OP_W-1:0]        op_s1;
	dbc_pkg::digits_t                digits_s1;

	// Block state and configuration.
	dbc_pkg::state_t                 state_q;
	dbc_pkg::state_t                 state_nxt;
	dbc_pkg::cfg_t                   cfg_q;
	logic                            done_nxt;

	// Result register.
	logic                            res_valid_q;
	dbc_pkg::digits_t                res_digits_q;
	logic                            res_off_q;
	logic                            res_done_q;

	logic                            advance;

	// The staged item moves on when the result register is free or being emptied.
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1        <= item.op;
			digits_s1[0] <= item.load_digit0;
			digits_s1[1] <= item.load_digit1;
			digits_s1[2] <= item.load_digit2;
			digits_s1[3] <= item.load_digit3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_time    <= dbc_pkg::OFF_TIME_RST;
			cfg_q.on_time     <= dbc_pkg::ON_TIME_RST;
			cfg_q.blink_mask  <= dbc_pkg::BLINK_MASK_RST;
			cfg_q.blink_count <= dbc_pkg::BLINK_COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				dbc_pkg::REG_OFF_TIME:    cfg_q.off_time <= cfg.data;
				dbc_pkg::REG_ON_TIME:     cfg_q.on_time <= cfg.data;
				dbc_pkg::REG_BLINK_MASK:  cfg_q.blink_mask <= cfg.data[dbc_pkg::MASK_W-1:0];
				dbc_pkg::REG_BLINK_COUNT: cfg_q.blink_count <= cfg.data[dbc_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dbc_step u_step (
		.cur         (state_q),
		.cfg         (cfg_q),
		.op          (op_s1),
		.load_digits (digits_s1),
		.nxt         (state_nxt),
		.done        (done_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_digits_q <= state_nxt.shown;
			res_off_q    <= state_nxt.off_phase;
			res_done_q   <= done_nxt;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.show_digit0  = res_digits_q[0];
	assign result.show_digit1  = res_digits_q[1];
	assign result.show_digit2  = res_digits_q[2];
	assign result.show_digit3  = res_digits_q[3];
	assign result.in_off_phase = res_off_q;
	assign result.run_done     = res_done_q;

endmodule

FILE: dv/digit_blink_controller_test.sv
// Self-checking testbench for the digit blink controller.
// Depends on dbc_pkg, the channel interfaces in dbc_if.sv and the RTL under hw/rtl.
`timescale 1ns / 1ps

module digit_blink_controller_test;
	import dbc_pkg::*;

	// Op codes the block must ignore, and a register index it must ignore.
	localparam logic [OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0]      OP_SPARE_LAST  = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 8'd4;

	// A correct run sends under 2k items. Even if each one waits out the longest
	// sender gap and sink stall, and every register write drains the block first,
	// it ends far below the limit here.
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	// Cycles to wait once the last result is in.
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 125;
	localparam int LONG_TICKS    = 100;

	// One input item as the controller sees it.
	typedef struct packed {
		logic [OP_W-1:0] op;
		digits_t         pats;
	} cmd_t;

	// One result: what the display shows after the item.
	typedef struct packed {
		digits_t shown;
		logic    off;
		logic    done;
	} view_t;

	logic clk;
	logic arst_n;

	dbc_item_if   item_ch();
	dbc_result_if result_ch();
	dbc_cfg_if    cfg_ch();

	digit_blink_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the controller: registers as last written, plus the blink
	// state that each accepted item moves forward.
	cfg_t                 regs;
	digits_t              kept_pat;
	digits_t              shown_pat;
	logic [TIME_BITS-1:0] elapsed;
	logic                 blanking;
	logic                 looping;
	logic                 counting;
	logic [COUNT_W-1:0]   blinks;

	// Displays still owed by the block, oldest first.
	view_t want_q[$];
	int    mismatches = 0;

	// Pacing switches. Both sides may idle while they are set.
	bit sender_pauses = 1'b1;
	bit sink_stalls   = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Start an off phase: blank every digit whose mask bit is set. Bit 3 of
	// the mask belongs to digit 0, bit 0 to digit 3.
	function automatic void blank_masked();
		blanking = 1'b1;
		elapsed  = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			shown_pat[i] = regs.blink_mask[DIGIT_COUNT-1-i] ? '0 : kept_pat[i];
		end
	endfunction

	// Both start commands set the repeat flag; a blink already under way is
	// left to run its course rather than being restarted.
	function automatic void start_blinking();
		looping = 1'b1;
		if (!blanking) begin
			blank_masked();
		end
	endfunction

	// Moves the shadow state by one item and returns the display that follows.
	function automatic view_t step_display(input cmd_t c);
		view_t v;
		v.done = 1'b0;
		case (c.op)
			OP_TICK: begin
				// The timer holds at its top value instead of wrapping.
				if (elapsed != '1) begin
					elapsed++;
				end
				// End of an off phase counts one blink; the counter holds at 255.
				if (blanking && elapsed >= regs.off_time) begin
					blanking  = 1'b0;
					shown_pat = kept_pat;
					elapsed   = '0;
					if (blinks != '1) begin
						blinks++;
					end
				end
				// The lit gap is over and blinking continues.
				if (looping && !blanking && elapsed >= regs.on_time) begin
					blank_masked();
				end
				// A counted run ends when the blink total meets a nonzero count.
				// This can happen just after a new blink started above; that
				// blink still runs to its end.
				if (counting && regs.blink_count != '0 && blinks == regs.blink_count) begin
					looping  = 1'b0;
					counting = 1'b0;
					v.done   = 1'b1;
				end
			end
			OP_START_CONT: begin
				start_blinking();
			end
			OP_START_COUNT: begin
				blinks   = '0;
				counting = 1'b1;
				start_blinking();
			end
			OP_STOP: begin
				looping = 1'b0;
			end
			OP_LOAD: begin
				// New patterns show in full even in the middle of an off phase.
				kept_pat  = c.pats;
				shown_pat = c.pats;
			end
			default: begin
				// Spare op codes leave everything as it is.
			end
		endcase
		v.shown = shown_pat;
		v.off   = blanking;
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic note_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("%0t ns: mismatch on %s: expected 'h%0h, got 'h%0h", $time, what, want, got);
		mismatches++;
	endtask

	// Every result transfer is held against the oldest display still owed.
	initial begin : result_check
		view_t   want;
		digits_t got;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got[0] = result_ch.show_digit0;
				got[1] = result_ch.show_digit1;
				got[2] = result_ch.show_digit2;
				got[3] = result_ch.show_digit3;
				if (want_q.size() == 0) begin
					note_mismatch("result with nothing expected", 0, got);
				end else begin
					want = want_q.pop_front();
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						if (got[i] !== want.shown[i]) begin
							note_mismatch($sformatf("show_digit%0d", i), want.shown[i], got[i]);
						end
					end
					if (result_ch.in_off_phase !== want.off) begin
						note_mismatch("in_off_phase", want.off, result_ch.in_off_phase);
					end
					if (result_ch.run_done !== want.done) begin
						note_mismatch("run_done", want.done, result_ch.run_done);
					end
				end
			end
		end
	end

	// The result sink drops ready in random bursts while stalls are on.
	initial begin : sink_pacing
		int stall;
		stall = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall == 0 && sink_stalls && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 10);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// A hung handshake ends the run here.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Sends one item and records the display it must produce. Valid is left
	// high on return, so the caller's next action in the same time step must be
	// another send or a drain; that keeps valid from dropping and rising in one
	// step when items go back to back.
	task automatic send_cmd(input logic [OP_W-1:0] op, input digits_t pats = '0);
		cmd_t c;
		c.op   = op;
		c.pats = pats;
		if (sender_pauses && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.op          <= op;
		item_ch.load_digit0 <= pats[0];
		item_ch.load_digit1 <= pats[1];
		item_ch.load_digit2 <= pats[2];
		item_ch.load_digit3 <= pats[3];
		do begin
			@(posedge clk);
		end while (item_ch.ready !== 1'b1);
		want_q.push_back(step_display(c));
	endtask

	// Stops sending and waits until every owed result has come back.
	task automatic drain_items();
		item_ch.valid <= 1'b0;
		while (want_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the controller idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_items();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do begin
			@(posedge clk);
		end while (cfg_ch.ready !== 1'b1);
		case (idx)
			REG_OFF_TIME:    regs.off_time    = data;
			REG_ON_TIME:     regs.on_time     = data;
			REG_BLINK_MASK:  regs.blink_mask  = data[MASK_W-1:0];
			REG_BLINK_COUNT: regs.blink_count = data[COUNT_W-1:0];
			default: begin
				// Unknown indexes are dropped by the block.
			end
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Writes all four registers. The mask and count sit in the low bits of the
	// data word; the bits above them are random and must be ignored.
	task automatic setup_blink(input logic [CFG_TIME_W-1:0] off_t, input logic [CFG_TIME_W-1:0] on_t,
			input logic [MASK_W-1:0] mask, input logic [COUNT_W-1:0] count);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_OFF_TIME, off_t);
		write_reg(REG_ON_TIME, on_t);
		write_reg(REG_BLINK_MASK, {junk[CFG_DATA_W-1:MASK_W], mask});
		write_reg(REG_BLINK_COUNT, {junk[CFG_DATA_W-1:COUNT_W], count});
	endtask

	// Segment patterns with all-off and all-on mixed in often.
	function automatic digits_t any_digits();
		digits_t d;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			case ($urandom_range(0, 5))
				0:       d[i] = '0;
				1:       d[i] = '1;
				default: d[i] = DIGIT_W'($urandom);
			endcase
		end
		return d;
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Walks every command through a short blink cycle with digits 0 and 2 masked.
	task automatic test_basic_commands();
		setup_blink(16'd2, 16'd1, 4'b1010, 8'd2);
		write_reg(REG_SPARE, 16'hFFFF);
		send_cmd(OP_TICK);
		send_cmd(OP_SPARE_FIRST, '1);
		send_cmd(OP_SPARE_LAST, '1);
		send_cmd(OP_LOAD, {8'h00, 8'hFF, 8'h00, 8'hFF});
		send_cmd(OP_LOAD, {8'hFF, 8'h00, 8'hFF, 8'h00});
		send_cmd(OP_STOP);
		// Continuous blinking; a load mid-blink shows in full, and a second
		// start must not restart the running off phase.
		send_cmd(OP_START_CONT);
		send_cmd(OP_LOAD, {8'h78, 8'h56, 8'h34, 8'h12});
		send_cmd(OP_START_CONT);
		repeat (3) send_cmd(OP_TICK);
		// A stop during an off phase lets that phase finish; the digits then stay lit.
		send_cmd(OP_STOP);
		repeat (3) send_cmd(OP_TICK);
		// Counted run of two blinks; run_done pulses on the closing tick.
		send_cmd(OP_START_COUNT);
		repeat (6) send_cmd(OP_TICK);
		// Re-arming during an off phase clears the blink total but keeps the phase.
		send_cmd(OP_START_COUNT);
		send_cmd(OP_TICK);
		send_cmd(OP_START_COUNT);
		repeat (6) send_cmd(OP_TICK);
	endtask

	// With both times at zero every tick closes one blink and opens the next.
	// That drives the blink total into saturation, and a count of 1 shows a run
	// ending on the same tick that a new blink starts.
	task automatic test_zero_length_phases();
		setup_blink(16'd0, 16'd0, 4'b1111, 8'd0);
		send_cmd(OP_LOAD, any_digits());
		send_cmd(OP_START_COUNT);
		repeat (300) send_cmd(OP_TICK);
		// The total held at 255, so a count of 255 now completes at once.
		write_reg(REG_BLINK_COUNT, 16'h00FF);
		repeat (2) send_cmd(OP_TICK);
		write_reg(REG_BLINK_COUNT, 16'h0001);
		send_cmd(OP_START_COUNT);
		repeat (4) send_cmd(OP_TICK);
		send_cmd(OP_STOP);
		send_cmd(OP_TICK);
	endtask

	// Both times at their largest: the off phase must stay blank through every
	// tick sent here, since neither compare may fire early.
	// Pacing is off here, so the ticks go back to back.
	task automatic test_longest_phases();
		sender_pauses = 1'b0;
		sink_stalls   = 1'b0;
		setup_blink(16'hFFFF, 16'hFFFF, 4'b0110, 8'd0);
		send_cmd(OP_LOAD, any_digits());
		send_cmd(OP_START_CONT);
		repeat (LONG_TICKS) send_cmd(OP_TICK);
		send_cmd(OP_STOP);
	endtask

	// Phases of random traffic, each under its own register setting. Ticks
	// dominate so that blinks and counted runs actually play out; the other
	// commands land at random points of each phase.
	task automatic test_random_traffic();
		int               pick;
		logic [OP_W-1:0]  op;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// The last two phases run with no idling on either side.
			sender_pauses = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
			sink_stalls   = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
			case (phase)
				0:       setup_blink(16'd0, 16'd0, 4'b0000, 8'd1);
				1:       setup_blink(CFG_TIME_W'($urandom_range(0, 3)),
						CFG_TIME_W'($urandom_range(0, 3)), 4'b1111, 8'd255);
				default: setup_blink(CFG_TIME_W'($urandom_range(0, 5)),
						CFG_TIME_W'($urandom_range(0, 5)), MASK_W'($urandom),
						COUNT_W'($urandom_range(0, 3)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					op = OP_TICK;
				end else if (pick < 76) begin
					op = OP_START_CONT;
				end else if (pick < 82) begin
					op = OP_START_COUNT;
				end else if (pick < 88) begin
					op = OP_STOP;
				end else if (pick < 97) begin
					op = OP_LOAD;
				end else begin
					op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				end
				send_cmd(op, any_digits());
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		regs      = '{OFF_TIME_RST, ON_TIME_RST, BLINK_MASK_RST, BLINK_COUNT_RST};
		kept_pat  = '0;
		shown_pat = '0;
		elapsed   = '0;
		blanking  = 1'b0;
		looping   = 1'b0;
		counting  = 1'b0;
		blinks    = '0;

		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.op          <= OP_TICK;
		item_ch.load_digit0 <= '0;
		item_ch.load_digit1 <= '0;
		item_ch.load_digit2 <= '0;
		item_ch.load_digit3 <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_OFF_TIME;
		cfg_ch.data         <= '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_zero_length_phases();
		test_longest_phases();
		test_random_traffic();
		drain_items();

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
